@@ hw/rtl/gnd_pkg.sv @@
`timescale 1ns / 1ps

package gnd_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;

  localparam int NB_SPAN   = 3;
  localparam int COORD_W   = 6;
  localparam int HOOD_SIZE = NB_SPAN * NB_SPAN;
  localparam int CAND_N    = 2 * HOOD_SIZE;

  // Signed working width for candidate cells; holds -1 and the largest grid size.
  localparam int SW = 12;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic KIND_REMOVE = 1'b0;
  localparam logic KIND_ADD    = 1'b1;

  typedef struct packed {
    logic [COORD_W-1:0] old_x;
    logic [COORD_W-1:0] old_y;
    logic [COORD_W-1:0] new_x;
    logic [COORD_W-1:0] new_y;
  } in_item_t;

  typedef struct packed {
    logic               change_kind;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_y;
    logic               run_end;
  } out_item_t;

  // One classified request: which of the 18 candidate cells are reported.
  // Bits 0..8 are the old neighborhood (remove), 9..17 the new one (add),
  // each in row-major order.
  typedef struct packed {
    logic [CAND_N-1:0] mask;
    in_item_t          coords;
  } job_t;

endpackage

@@ hw/rtl/gnd_front.sv @@
`timescale 1ns / 1ps

module gnd_front (
  input  logic            in_valid,
  output logic            in_stall,
  input  gnd_pkg::in_item_t in_data,
  input  logic            q_full,
  output logic            q_push,
  output gnd_pkg::job_t   q_job
);
  import gnd_pkg::*;

  logic [CAND_N-1:0] mask;

  always_comb begin
    logic [COORD_W-1:0] px, py, qx, qy;
    logic signed [SW-1:0] cx, cy, dx, dy;
    logic on_grid, near;
    mask = '0;
    px = '0;
    py = '0;
    qx = '0;
    qy = '0;
    cx = '0;
    cy = '0;
    dx = '0;
    dy = '0;
    on_grid = 1'b0;
    near = 1'b0;
    for (int k = 0; k < 2; k++) begin
      px = (k == 0) ? in_data.old_x : in_data.new_x;
      py = (k == 0) ? in_data.old_y : in_data.new_y;
      qx = (k == 0) ? in_data.new_x : in_data.old_x;
      qy = (k == 0) ? in_data.new_y : in_data.old_y;
      for (int r = 0; r < NB_SPAN; r++) begin
        for (int c = 0; c < NB_SPAN; c++) begin
          cx = $signed({{(SW-COORD_W){1'b0}}, px}) + SW'(c) - SW'(1);
          cy = $signed({{(SW-COORD_W){1'b0}}, py}) + SW'(r) - SW'(1);
          dx = cx - $signed({{(SW-COORD_W){1'b0}}, qx});
          dy = cy - $signed({{(SW-COORD_W){1'b0}}, qy});
          on_grid = (cx >= SW'(0)) && (cx < SW'(GRID_WIDTH)) &&
                    (cy >= SW'(0)) && (cy < SW'(GRID_HEIGHT));
          near = (dx >= -SW'(1)) && (dx <= SW'(1)) && (dy >= -SW'(1)) && (dy <= SW'(1));
          mask[k*HOOD_SIZE + r*NB_SPAN + c] = on_grid && !near;
        end
      end
    end
  end

  // Requests that report nothing are taken and dropped here.
  assign in_stall     = q_full;
  assign q_push       = in_valid && !q_full && (|mask);
  assign q_job.mask   = mask;
  assign q_job.coords = in_data;

endmodule

@@ hw/rtl/gnd_queue.sv @@
`timescale 1ns / 1ps

module gnd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gnd_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output gnd_pkg::job_t head_job
);
  import gnd_pkg::*;

  job_t              q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

@@ hw/rtl/gnd_back.sv @@
`timescale 1ns / 1ps

module gnd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  gnd_pkg::job_t     q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output gnd_pkg::out_item_t out_data
);
  import gnd_pkg::*;

  logic              work_valid_r, work_valid_nxt;
  logic [CAND_N-1:0] work_mask_r, work_mask_nxt;
  in_item_t          work_coords_r, work_coords_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  logic              pick_kind;
  logic [1:0]        pick_r, pick_c;
  logic [CAND_N-1:0] pick_onehot;
  logic [CAND_N-1:0] rest;
  logic [COORD_W-1:0] base_x, base_y;
  logic              adv, emit, work_done;

  // Lowest set candidate wins; the loops run high to low so it is written last.
  always_comb begin
    pick_kind   = KIND_REMOVE;
    pick_r      = '0;
    pick_c      = '0;
    pick_onehot = '0;
    for (int k = 1; k >= 0; k--) begin
      for (int r = NB_SPAN - 1; r >= 0; r--) begin
        for (int c = NB_SPAN - 1; c >= 0; c--) begin
          if (work_mask_r[k*HOOD_SIZE + r*NB_SPAN + c]) begin
            pick_kind   = (k == 1) ? KIND_ADD : KIND_REMOVE;
            pick_r      = 2'(r);
            pick_c      = 2'(c);
            pick_onehot = '0;
            pick_onehot[k*HOOD_SIZE + r*NB_SPAN + c] = 1'b1;
          end
        end
      end
    end
  end

  assign rest      = work_mask_r & ~pick_onehot;
  assign base_x    = (pick_kind == KIND_ADD) ? work_coords_r.new_x : work_coords_r.old_x;
  assign base_y    = (pick_kind == KIND_ADD) ? work_coords_r.new_y : work_coords_r.old_y;
  assign adv       = !out_valid_r || !out_stall;
  assign emit      = adv && work_valid_r;
  assign work_done = !work_valid_r || (emit && (rest == '0));
  assign q_pop     = work_done && q_valid;

  always_comb begin
    work_valid_nxt  = work_valid_r;
    work_mask_nxt   = work_mask_r;
    work_coords_nxt = work_coords_r;
    out_valid_nxt   = out_valid_r;
    out_data_nxt    = out_data_r;
    if (q_pop) begin
      work_valid_nxt  = 1'b1;
      work_mask_nxt   = q_job.mask;
      work_coords_nxt = q_job.coords;
    end else if (emit) begin
      work_valid_nxt = (rest != '0);
      work_mask_nxt  = rest;
    end
    if (adv) begin
      out_valid_nxt = emit;
    end
    if (emit) begin
      // Columns and rows wrap modulo 64 when the grid is larger than the field.
      out_data_nxt.change_kind = pick_kind;
      out_data_nxt.cell_x      = base_x + COORD_W'(pick_c) - COORD_W'(1);
      out_data_nxt.cell_y      = base_y + COORD_W'(pick_r) - COORD_W'(1);
      out_data_nxt.run_end     = (rest == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      work_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      work_valid_r <= work_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_mask_r   <= work_mask_nxt;
    work_coords_r <= work_coords_nxt;
    out_data_r    <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hw/rtl/grid_neighbourhood_diff_top.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Ports                          Payload
// input     in         in_valid, in_stall, in_data    old and new cell (in_item_t)
// result    out        out_valid, out_stall, out_data kind, cell, run_end (out_item_t)
//
// A request yields 0 to 18 results; the back end issues one result per cycle
// while out_stall is low, so a request occupies it until all its results are issued.
// A request with no results is taken and produces nothing.
// A two-entry queue between classifier and issue unit lets new requests be
// taken while results drain; in_stall is high only while that queue is full.
// Reset is synchronous and active low; it empties the queue and the output.

module grid_neighbourhood_diff_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  gnd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output gnd_pkg::out_item_t out_data
);
  import gnd_pkg::*;

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_push_job, q_head_job;

  gnd_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_job    (q_push_job)
  );

  gnd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  gnd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_head_valid),
    .q_job     (q_head_job),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/gnd_checker.sv @@
`timescale 1ns / 1ps

module gnd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input gnd_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input gnd_pkg::out_item_t out_data
);
  import gnd_pkg::*;

  // A stalled request holds its value.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("request changed while stalled");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset leaves no result pending and the queue with room.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not empty after reset");

  // Within one request all removes come before all adds.
  a_kind_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.run_end && (out_data.change_kind == KIND_ADD)
    |=> !out_valid || (out_data.change_kind == KIND_ADD))
    else $error("remove result followed an add in the same request");

endmodule

bind grid_neighbourhood_diff_top gnd_checker u_gnd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
